// File: design/sv39_page_table_walk_macros.svh
// ---------------------------------------------------------------------------
// Sv39 page table walker assertion macros
// Shared property shapes for the checker; clocked on clk_i, off in reset.
// ---------------------------------------------------------------------------
`ifndef SV39_PAGE_TABLE_WALK_MACROS_SVH
`define SV39_PAGE_TABLE_WALK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SV39PTW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SV39PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sv39ptw_pkg.sv
// ---------------------------------------------------------------------------
// Sv39 page table walker package
// Field widths, stream layouts, entry bit positions and result codes.
// ---------------------------------------------------------------------------
package sv39ptw_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_TABLE_PAGES   = 16;
  localparam int unsigned DEF_VA_LIMIT_BITS = 38;

  // Sv39 geometry
  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned LEVEL_BITS       = 9;
  localparam int unsigned PAGE_SHIFT       = 12;
  localparam int unsigned VPN_W            = 3 * LEVEL_BITS;
  localparam int unsigned PPN_W            = 44;
  localparam int unsigned PA_W             = 56;
  localparam int unsigned VA_W             = 64;
  localparam int unsigned PTE_W            = 64;
  localparam int unsigned PTE_PPN_LSB      = 10;
  localparam int unsigned PTE_V_BIT        = 0;
  localparam int unsigned PTE_U_BIT        = 4;

  localparam logic [1:0] LEVEL_TOP  = 2'd2;
  localparam logic [1:0] LEVEL_LEAF = 2'd0;

  // Stream layouts
  localparam int unsigned ENTRY_INDEX_W = 13;
  localparam int unsigned FAULT_W       = 3;
  localparam int unsigned S_TDATA_W     = ((ENTRY_INDEX_W + PTE_W + VA_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W     = ((PA_W + FAULT_W + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_W     = 1;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_XLATE = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT = 1'b0,
    CFG_BASE = 1'b1
  } cfg_idx_e;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_OK           = 3'd0,
    FAULT_HIGH         = 3'd1,
    FAULT_INNER        = 3'd2,
    FAULT_LEAF_INVALID = 3'd3,
    FAULT_NOT_USER     = 3'd4,
    FAULT_OUTSIDE      = 3'd5
  } fault_e;

endpackage

// File: design/sv39ptw_store.sv
// ---------------------------------------------------------------------------
// Sv39 page table store
// Single-port-write, single-port-read table memory with registered read data.
// ---------------------------------------------------------------------------
module sv39ptw_store #(
  parameter int unsigned DEPTH  = 8192,
  parameter int unsigned ADDR_W = 13
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [ADDR_W-1:0]              wr_addr_i,
  input  logic [sv39ptw_pkg::PTE_W-1:0]  wr_data_i,
  input  logic                           rd_en_i,
  input  logic [ADDR_W-1:0]              rd_addr_i,
  output logic [sv39ptw_pkg::PTE_W-1:0]  rd_data_o
);
  import sv39ptw_pkg::*;

  logic [PTE_W-1:0] mem_q [DEPTH];
  logic [PTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/sv39_page_table_walk.sv
// ---------------------------------------------------------------------------
// Sv39 page table walk: three-level translation over a local table store
// Table writes go straight into the store. A translation makes up to three
// dependent reads of the single store read port, one per level (none on an
// address-too-high or root-outside fault); no new item is taken until its result is registered.
// Reset: control registers clear; a sweep zeroes the store, input stalled meanwhile.
// ---------------------------------------------------------------------------
module sv39_page_table_walk #(
  parameter int unsigned TABLE_PAGES   = sv39ptw_pkg::DEF_TABLE_PAGES,
  parameter int unsigned VA_LIMIT_BITS = sv39ptw_pkg::DEF_VA_LIMIT_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sv39ptw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sv39ptw_pkg::PPN_W-1:0]       cfg_data_i,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low bit up: entry_index[12:0], entry_value[63:0],
  // virtual_address[63:0], zero pad
  input  logic [sv39ptw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // tuser: mode (0 write entry, 1 translate)
  input  logic                                s_axis_tuser,
  // results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, low bit up: physical_page_address[55:0], fault[2:0], zero pad
  output logic [sv39ptw_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import sv39ptw_pkg::*;

  localparam int unsigned StoreWords = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int unsigned AddrW      = $clog2(StoreWords);
  localparam int unsigned IdxExtW    = (AddrW > ENTRY_INDEX_W) ? AddrW : ENTRY_INDEX_W;

  // Walk sequencer. CLEAR sweeps the store after reset, WALK waits on one
  // table read per level, HOLD carries a fault found at accept time.
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [AddrW-1:0]    clr_q, clr_d;
  logic [1:0]          level_q, level_d;
  logic [VPN_W-1:0]    vpn_q, vpn_d;
  fault_e              hold_fault_q, hold_fault_d;

  logic [PPN_W-1:0]    root_q, base_q;

  logic                m_valid_q;
  logic [PA_W-1:0]     m_addr_q;
  fault_e              m_fault_q;

  // Unpack the input transaction
  mode_e               in_mode;
  logic [ENTRY_INDEX_W-1:0] in_index;
  logic [PTE_W-1:0]    in_value;
  logic [VA_W-1:0]     in_va;
  logic                in_accept;

  assign in_mode   = mode_e'(s_axis_tuser);
  assign in_index  = s_axis_tdata[0 +: ENTRY_INDEX_W];
  assign in_value  = s_axis_tdata[ENTRY_INDEX_W +: PTE_W];
  assign in_va     = s_axis_tdata[ENTRY_INDEX_W + PTE_W +: VA_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  // Configuration: always ready; the user must write it only while the walker is idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
      base_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROOT: root_q <= cfg_data_i;
        CFG_BASE: base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Table store
  logic              wr_en, rd_en;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic [PTE_W-1:0]  wr_data, pte;

  sv39ptw_store #(
    .DEPTH  (StoreWords),
    .ADDR_W (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (pte)
  );

  // Writes beyond the store are dropped. The sweep owns the write port until
  // it finishes; no item is taken meanwhile, so the two never collide.
  logic index_in_store;
  assign index_in_store = 32'(in_index) < StoreWords;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else begin
      wr_en   = in_accept && (in_mode == MODE_WRITE) && index_in_store;
      wr_addr = AddrW'(IdxExtW'(in_index));
      wr_data = in_value;
    end
  end

  // Range check of the next table page: the root when an item arrives, the
  // pointer from the entry just read when walking. Reads only happen in
  // IDLE and WALK, and writes only in CLEAR and in IDLE with no walk in flight, so a
  // read never overlaps a write to the same entry.
  logic [PPN_W-1:0]      chk_ppn;
  logic [PPN_W:0]        page_diff;
  logic                  outside;
  logic [LEVEL_BITS-1:0] rd_idx;
  logic                  va_high;

  assign chk_ppn   = (state_q == ST_IDLE) ? root_q : pte[PTE_PPN_LSB +: PPN_W];
  assign page_diff = {1'b0, chk_ppn} - {1'b0, base_q};
  assign outside   = page_diff[PPN_W] ||
                     (page_diff[PPN_W-1:0] >= PPN_W'(TABLE_PAGES));
  assign va_high   = (in_va >> VA_LIMIT_BITS) != '0;

  always_comb begin
    if (state_q == ST_IDLE) begin
      rd_idx = in_va[PAGE_SHIFT + 2 * LEVEL_BITS +: LEVEL_BITS];
    end else if (level_q == LEVEL_TOP) begin
      rd_idx = vpn_q[LEVEL_BITS +: LEVEL_BITS];
    end else begin
      rd_idx = vpn_q[0 +: LEVEL_BITS];
    end
  end

  assign rd_addr = AddrW'({page_diff[PPN_W-1:0], rd_idx});

  // Result side
  logic        out_free;
  logic        res_valid;
  fault_e      res_fault;
  logic [PA_W-1:0] res_addr;

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    level_d      = level_q;
    vpn_d        = vpn_q;
    hold_fault_d = hold_fault_q;
    rd_en        = 1'b0;
    res_valid    = 1'b0;
    res_fault    = FAULT_OK;
    res_addr     = '0;

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(StoreWords - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept && (in_mode == MODE_XLATE)) begin
          vpn_d = in_va[PAGE_SHIFT +: VPN_W];
          if (va_high) begin
            hold_fault_d = FAULT_HIGH;
            state_d      = ST_HOLD;
          end else if (outside) begin
            hold_fault_d = FAULT_OUTSIDE;
            state_d      = ST_HOLD;
          end else begin
            // issue the top-level read right away
            rd_en   = 1'b1;
            level_d = LEVEL_TOP;
            state_d = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (level_q != LEVEL_LEAF) begin
          // inner entry: any valid entry is a pointer
          if (!pte[PTE_V_BIT]) begin
            res_valid = 1'b1;
            res_fault = FAULT_INNER;
          end else if (outside) begin
            res_valid = 1'b1;
            res_fault = FAULT_OUTSIDE;
          end else begin
            rd_en   = 1'b1;
            level_d = level_q - 1'b1;
          end
        end else begin
          res_valid = 1'b1;
          if (!pte[PTE_V_BIT]) begin
            res_fault = FAULT_LEAF_INVALID;
          end else if (!pte[PTE_U_BIT]) begin
            res_fault = FAULT_NOT_USER;
          end else begin
            res_fault = FAULT_OK;
            res_addr  = {pte[PTE_PPN_LSB +: PPN_W], {PAGE_SHIFT{1'b0}}};
          end
        end
        // hold the read data until the output register frees up
        if (res_valid && out_free) begin
          state_d = ST_IDLE;
        end
      end

      ST_HOLD: begin
        res_valid = 1'b1;
        res_fault = hold_fault_q;
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      level_q      <= LEVEL_TOP;
      hold_fault_q <= FAULT_OK;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      level_q      <= level_d;
      hold_fault_q <= hold_fault_d;
      if (res_valid && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    vpn_q <= vpn_d;
    if (res_valid && out_free) begin
      m_addr_q  <= res_addr;
      m_fault_q <= res_fault;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({FAULT_W'(m_fault_q), m_addr_q});

endmodule

// File: design/sv39ptw_checker.sv
// ---------------------------------------------------------------------------
// Sv39 page table walker port checker
// Watches the stream ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
`include "sv39_page_table_walk_macros.svh"

module sv39ptw_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sv39ptw_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import sv39ptw_pkg::*;

  logic [PA_W-1:0]    m_addr;
  logic [FAULT_W-1:0] m_fault;
  logic               wr_accept, xl_accept;

  assign m_addr    = m_axis_tdata[0 +: PA_W];
  assign m_fault   = m_axis_tdata[PA_W +: FAULT_W];
  assign wr_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_WRITE);
  assign xl_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_XLATE);

  `SV39PTW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `SV39PTW_ASSERT_SAME(a_fault_zero, m_axis_tvalid && (m_fault != FAULT_OK), m_addr == '0, "faulted result carries an address")
  `SV39PTW_ASSERT_SAME(a_fault_code, m_axis_tvalid, m_fault <= FAULT_OUTSIDE, "fault code out of range")
  `SV39PTW_ASSERT_NEXT(a_write_silent, wr_accept && !m_axis_tvalid, !m_axis_tvalid, "table write produced a result")
  `SV39PTW_ASSERT_NEXT(a_walk_busy, xl_accept, !s_axis_tready, "input taken during a walk")

endmodule

bind sv39_page_table_walk sv39ptw_checker u_checker (.*);

// File: tb/sv39_walk_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sv39 walk checker
// Watches the register, item and result channels, keeps its own table store
// and register copies, predicts every translation and compares each result.
// ---------------------------------------------------------------------------
module sv39_walk_checker
  import sv39ptw_pkg::*;
#(
  parameter int unsigned TABLE_PAGES   = DEF_TABLE_PAGES,
  parameter int unsigned VA_LIMIT_BITS = DEF_VA_LIMIT_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PPN_W-1:0]     cfg_data_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  // entry_index[12:0], entry_value[63:0], virtual_address[63:0], zero pad
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  // mode
  input  logic                 s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  // physical_page_address[55:0], fault[2:0], zero pad
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o,
  output int unsigned          mapped_o
);

  localparam int unsigned STORE_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;

  typedef struct packed {
    logic [PA_W-1:0] pa;
    fault_e          fault;
  } xlate_t;

  logic [PTE_W-1:0] entry_mem [STORE_WORDS];
  logic [PPN_W-1:0] root_q;
  logic [PPN_W-1:0] base_q;
  xlate_t           expected_xlate_q [$];

  // Walk the local store the way the block must, level 2 down to the leaf.
  function automatic xlate_t predict_translation(logic [VA_W-1:0] va);
    xlate_t           res;
    logic [PPN_W-1:0] ppn;
    logic [PPN_W-1:0] offs;
    logic [PTE_W-1:0] pte;
    logic [VA_W-1:0]  vpn;
    int               lvl;
    res.pa    = '0;
    res.fault = FAULT_OK;
    ppn       = root_q;
    pte       = '0;
    if ((va >> VA_LIMIT_BITS) != 0) begin
      res.fault = FAULT_HIGH;
      return res;
    end
    for (lvl = int'(LEVEL_TOP); lvl >= int'(LEVEL_LEAF); lvl--) begin
      vpn = (va >> (PAGE_SHIFT + LEVEL_BITS * lvl)) & (ENTRIES_PER_PAGE - 1);
      // the table page must sit inside the store before it is read
      if (ppn < base_q) begin
        res.fault = FAULT_OUTSIDE;
        return res;
      end
      offs = ppn - base_q;
      if (offs >= TABLE_PAGES) begin
        res.fault = FAULT_OUTSIDE;
        return res;
      end
      pte = entry_mem[offs * ENTRIES_PER_PAGE + vpn];
      if (lvl > int'(LEVEL_LEAF)) begin
        // any valid inner entry is a pointer, R/W/X ignored
        if (!pte[PTE_V_BIT]) begin
          res.fault = FAULT_INNER;
          return res;
        end
        ppn = pte[PTE_PPN_LSB +: PPN_W];
      end
    end
    if (!pte[PTE_V_BIT]) begin
      res.fault = FAULT_LEAF_INVALID;
      return res;
    end
    if (!pte[PTE_U_BIT]) begin
      res.fault = FAULT_NOT_USER;
      return res;
    end
    res.pa = {pte[PTE_PPN_LSB +: PPN_W], {PAGE_SHIFT{1'b0}}};
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    xlate_t            want;
    logic [PA_W-1:0]   got_pa;
    logic [FAULT_W-1:0] got_fault;
    if (!rst_ni) begin
      for (int i = 0; i < STORE_WORDS; i++) entry_mem[i] = '0;
      root_q = '0;
      base_q = '0;
      expected_xlate_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      mapped_o     = 0;
    end else begin
      // results first: a result this edge belongs to an older translation
      if (m_tvalid_i && m_tready_i) begin
        got_pa    = m_tdata_i[PA_W-1:0];
        got_fault = m_tdata_i[PA_W +: FAULT_W];
        if (expected_xlate_q.size() == 0) begin
          report_mismatch("result with no translation pending", 64'(m_tdata_i), '0);
        end else begin
          want = expected_xlate_q.pop_front();
          checked_o++;
          if (got_pa !== want.pa) report_mismatch("physical_page_address", 64'(got_pa),
                                                  64'(want.pa));
          if (got_fault !== want.fault) report_mismatch("fault", 64'(got_fault),
                                                        64'(want.fault));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ROOT: root_q = cfg_data_i;
          CFG_BASE: base_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        if (mode_e'(s_tuser_i) == MODE_WRITE) begin
          // writes past the store are dropped
          if (s_tdata_i[ENTRY_INDEX_W-1:0] < STORE_WORDS)
            entry_mem[s_tdata_i[ENTRY_INDEX_W-1:0]] = s_tdata_i[ENTRY_INDEX_W +: PTE_W];
        end else begin
          want = predict_translation(s_tdata_i[ENTRY_INDEX_W + PTE_W +: VA_W]);
          if (want.fault == FAULT_OK) mapped_o++;
          expected_xlate_q.push_back(want);
        end
      end
      pending_o = expected_xlate_q.size();
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sv39 page table walk testbench
// Builds page tables through write transactions, translates addresses under
// several root and store-base settings, and lets the checker score results.
// ---------------------------------------------------------------------------
module tb;
  import sv39ptw_pkg::*;

  localparam int unsigned TABLE_PAGES   = DEF_TABLE_PAGES;
  localparam int unsigned VA_LIMIT_BITS = DEF_VA_LIMIT_BITS;
  localparam int unsigned S_PAD_W       = S_TDATA_W - ENTRY_INDEX_W - PTE_W - VA_W;
  localparam logic [PPN_W-1:0] PPN_MAX  = '1;
  localparam logic [VA_W-1:0] VA_MASK   = (64'd1 << VA_LIMIT_BITS) - 64'd1;
  localparam logic [9:0] FLAG_V         = 10'(1 << PTE_V_BIT);
  localparam logic [9:0] FLAG_U         = 10'(1 << PTE_U_BIT);
  // Budget for the slowest correct run, with a tenfold margin: the clearing
  // sweep, about 1450 transactions with random idling on each side, one long
  // hold-off and a settle per phase.
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned HOLDOFF_CYCLES = 400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [PPN_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned mapped;

  // stimulus bookkeeping
  int unsigned      items_sent;
  int unsigned      settings_used;
  int unsigned      cycle_count;
  bit               quiet;          // no idling on either side while set
  bit               start_holdoff;  // ask the result sink for one long stall
  logic [PPN_W-1:0] plan_root;
  logic [PPN_W-1:0] plan_base;

  sv39_page_table_walk #(
    .TABLE_PAGES  (TABLE_PAGES),
    .VA_LIMIT_BITS(VA_LIMIT_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  sv39_walk_checker #(
    .TABLE_PAGES  (TABLE_PAGES),
    .VA_LIMIT_BITS(VA_LIMIT_BITS)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .mapped_o    (mapped)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Guard the whole run; a hang ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("== FAIL ==");
    $finish;
  end

  // Result sink: random back-pressure, plus one long hold-off on request so
  // the walker backs up and stalls its input.
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_used;
    hold_left     = 0;
    hold_used     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (start_holdoff && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Entry layout: top bits 63..54, page number 53..10, flags 9..0.
  function automatic logic [PTE_W-1:0] make_pte(logic [PPN_W-1:0] ppn, logic [9:0] flags,
                                                logic [9:0] top_bits);
    return {top_bits, ppn, flags};
  endfunction

  function automatic logic [ENTRY_INDEX_W-1:0] store_index(int unsigned page,
                                                           int unsigned entry);
    return ENTRY_INDEX_W'(page * ENTRIES_PER_PAGE + entry);
  endfunction

  // Offer one item at a falling edge and hold it until the transaction
  // completes; return at the next falling edge with tvalid still high.
  task automatic send_item(mode_e mode, logic [ENTRY_INDEX_W-1:0] idx,
                           logic [PTE_W-1:0] value, logic [VA_W-1:0] va);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{S_PAD_W{1'b0}}, va, value, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Unused fields carry random bits so every non-pad input bit toggles.
  task automatic write_entry(logic [ENTRY_INDEX_W-1:0] idx, logic [PTE_W-1:0] value);
    send_item(MODE_WRITE, idx, value, rand64());
  endtask

  task automatic translate(logic [VA_W-1:0] va);
    logic [63:0] r;
    r = rand64();
    send_item(MODE_XLATE, r[ENTRY_INDEX_W-1:0], rand64(), va);
  endtask

  // Drop the item stream and wait until the walker is idle: every result in,
  // then a wait for a trailing write to land.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Return at the next falling edge with valid still high; the caller drops it.
  task automatic write_reg(cfg_idx_e idx, logic [PPN_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_regs(logic [PPN_W-1:0] root, logic [PPN_W-1:0] base);
    settle();
    write_reg(CFG_BASE, base);
    write_reg(CFG_ROOT, root);
    cfg_valid_i <= 1'b0;
    plan_root = root;
    plan_base = base;
    settings_used++;
  endtask

  // Build one three-level mapping for a random address, then translate it
  // and up to two neighbors. A slice of the sequences is broken on purpose:
  // pointers outside the store, odd leaf flags, or a skipped level write.
  task automatic walk_sequence();
    logic [63:0]      r;
    logic [VA_W-1:0]  va;
    logic [VA_W-1:0]  va_near;
    logic [PPN_W-1:0] root_off;
    logic [PPN_W-1:0] l1_pn;
    logic [PPN_W-1:0] l0_pn;
    logic [9:0]       leaf_flags;
    int unsigned      root_pg;
    int unsigned      l1;
    int unsigned      l0;
    int unsigned      kind;
    int unsigned      extra;
    r        = rand64();
    va       = r & VA_MASK;
    root_off = plan_root - plan_base;
    root_pg  = (root_off < TABLE_PAGES) ? int'(root_off) : $urandom_range(0, TABLE_PAGES - 1);
    l1       = $urandom_range(0, TABLE_PAGES - 1);
    l0       = $urandom_range(0, TABLE_PAGES - 1);
    l1_pn    = plan_base + PPN_W'(l1);
    l0_pn    = plan_base + PPN_W'(l0);
    kind     = $urandom_range(0, 99);
    if (kind < 4) l1_pn = plan_base - PPN_W'(1 + $urandom_range(0, 3));
    else if (kind < 8) l0_pn = plan_base + PPN_W'(TABLE_PAGES + $urandom_range(0, 3));
    r = rand64();
    leaf_flags = (kind >= 8 && kind < 14) ? r[9:0] : (r[9:0] | FLAG_V | FLAG_U);
    if (kind != 14) begin
      r = rand64();
      write_entry(store_index(root_pg, int'(va[38:30])), make_pte(l1_pn, r[9:0] | FLAG_V,
                                                                 r[63:54]));
    end
    if (kind != 15) begin
      r = rand64();
      write_entry(store_index(l1, int'(va[29:21])), make_pte(l0_pn, r[9:0] | FLAG_V,
                                                             r[63:54]));
    end
    if (kind != 16) begin
      r = rand64();
      write_entry(store_index(l0, int'(va[20:12])), make_pte(r[PPN_W-1:0], leaf_flags,
                                                             r[63:54]));
    end
    translate(va);
    extra = $urandom_range(0, 2);
    repeat (extra) begin
      r       = rand64();
      va_near = {va[VA_W-1:12], r[11:0]};
      if (r[12]) va_near[20:12] = r[29:21];
      translate(va_near);
    end
  endtask

  // Mostly well-formed walks, the rest stray translations and stray writes.
  task automatic random_phase(int unsigned goal);
    logic [63:0] r;
    int unsigned pick;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      r    = rand64();
      if (pick < 70) walk_sequence();
      else if (pick < 85) translate(r[13] ? r : (r & VA_MASK));
      else write_entry(r[ENTRY_INDEX_W-1:0], rand64());
    end
  endtask

  initial begin : stimulus
    logic [63:0] r;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_ROOT;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = MODE_WRITE;
    s_axis_tdata  = '0;
    quiet         = 1'b0;
    start_holdoff = 1'b0;
    items_sent    = 0;
    settings_used = 1;
    plan_root     = '0;
    plan_base     = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset settings: root page 0 = store page 0.
    translate('0);                               // empty store, inner invalid
    translate(64'd1 << VA_LIMIT_BITS);           // first address too high
    translate('1);                               // all ones, too high
    translate(VA_MASK);                          // highest legal address
    write_entry(store_index(0, 0), make_pte(PPN_W'(1), FLAG_V, '0));
    write_entry(store_index(1, 0), make_pte(PPN_W'(2), FLAG_V, '0));
    write_entry(store_index(2, 0), '1);          // widest leaf, every bit set
    translate('0);
    write_entry(store_index(2, 1), make_pte(PPN_MAX, FLAG_V, '1));  // not user
    translate(64'h1000);
    write_entry(store_index(2, 2), ~64'd1);      // user bit set, valid clear
    translate(64'h2fff);
    // pointer to the page just past the store
    write_entry(store_index(0, 1), make_pte(PPN_W'(TABLE_PAGES), FLAG_V, '0));
    translate(64'd1 << 30);
    // leaf-shaped inner entry (R/W/X set) still acts as a pointer
    write_entry(store_index(0, 2), make_pte(PPN_W'(1), 10'h00f, '0));
    translate((64'd2 << 30) | 64'habc);
    write_entry(store_index(TABLE_PAGES - 1, ENTRIES_PER_PAGE - 1), rand64());
    write_entry(store_index(0, 3), '0);
    translate(64'd3 << 30);
    translate(64'd5 << 21);                      // level-1 entry never written

    // Phase: root inside the store at base 0; one long hold-off on results.
    set_regs(PPN_W'(5), '0);
    start_holdoff = 1'b1;
    random_phase(items_sent + 400);

    // Phase: store based at a random page, root somewhere inside it.
    r = rand64();
    set_regs((r[PPN_W-1:0] & (PPN_MAX >> 1)) + PPN_W'($urandom_range(0, TABLE_PAGES - 1)),
             r[PPN_W-1:0] & (PPN_MAX >> 1));
    random_phase(items_sent + 350);

    // Phase: store at the very top of the page space, no idling at all.
    set_regs(PPN_MAX, PPN_MAX - PPN_W'(TABLE_PAGES - 1));
    quiet = 1'b1;
    random_phase(items_sent + 300);
    quiet = 1'b0;

    // Phase: a single addressable store page, everything else outside.
    set_regs(PPN_MAX, PPN_MAX);
    random_phase(items_sent + 60);

    // Phase: root far outside the store, every translation faults early.
    set_regs(PPN_MAX, '0);
    random_phase(items_sent + 40);

    // Phase: back to the low extreme.
    set_regs('0, '0);
    random_phase(items_sent + 280);

    // Drain: every result in, then a margin for the walker's latency.
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);

    $display("Sent %0d item transactions under %0d register settings;", items_sent,
             settings_used);
    $display("checked %0d translations, %0d of them mapped, %0d mismatches.", checked, mapped,
             fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/sv39ptw_pkg.sv
design/sv39ptw_store.sv
design/sv39_page_table_walk.sv
design/sv39ptw_checker.sv
tb/sv39_walk_checker.sv
tb/tb.sv
